// ===== sv/gapf_pkg.sv =====
// Shared types, constants and helpers of the grid path finder.
// No dependencies; every other file of the block imports this package.
package gapf_pkg;

  localparam logic OP_CELL = 1'b0;
  localparam logic OP_PATH = 1'b1;

  localparam logic [15:0] SCORE_CAP  = 16'd12800;
  localparam logic [15:0] W_STRAIGHT = 16'd256;
  localparam logic [15:0] W_DIAG     = 16'd362;
  localparam logic [2:0]  DIR_LAST   = 3'd7;
  localparam logic [2:0]  DIR_FIRST_DIAG = 3'd4;
  localparam logic [31:0] ROOT_BIT_TOP = 32'h4000_0000;
  localparam logic [4:0]  SIDE_RESET = 5'd10;

  typedef struct packed {
    logic       operation;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic       cell_blocked;
    logic       cell_occupied;
    logic [3:0] start_x;
    logic [3:0] start_y;
    logic [3:0] goal_x;
    logic [3:0] goal_y;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] step_x;
    logic [3:0] step_y;
    logic [3:0] step_index;
    logic       last;
  } out_t;

  typedef struct packed {
    logic clear_step;
    logic cell_wr;
    logic load_req;
    logic goal_rd;
    logic init;
    logic min_init;
    logic min_scan;
    logic min_pick;
    logic cur_load;
    logic nb_init;
    logic nb_scan;
    logic nb_slot;
    logic nb_jread;
    logic nb_upd;
    logic tr_init;
    logic tr_step;
    logic tr_par;
    logic tr_pl;
    logic em_out;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic goal_bad;
    logic scan_done;
    logic best_valid;
    logic at_goal;
    logic j_found;
    logic store_full;
    logic sqrt_done;
    logic dir_last;
    logic path_over;
    logic trace_end;
    logic em_last;
  } stat_t;

  // Neighbor order: four straight steps, then four diagonal steps.
  function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
    logic signed [1:0] v;
    unique case (d)
      3'd0, 3'd6, 3'd7: v = 2'sd1;
      3'd1, 3'd2:       v = 2'sd0;
      default:          v = -2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
    logic signed [1:0] v;
    unique case (d)
      3'd1, 3'd4, 3'd6: v = 2'sd1;
      3'd0, 3'd3:       v = 2'sd0;
      default:          v = -2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== sv/gapf_isqrt.sv =====
// Iterative square root, computed bit by bit from the top weight, rounded to nearest.
// Depends on gapf_pkg for the starting bit weight.
module gapf_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] n,
  output logic        done,
  output logic [15:0] root
);
  import gapf_pkg::*;

  logic [31:0] rem, res, bitq;
  logic [31:0] trial;

  assign trial = res + bitq;
  assign done  = (bitq == '0);
  assign root  = 16'(res + 32'(rem > res));

  always_ff @(posedge clk) begin
    if (rst) begin
      bitq <= '0;
    end else if (start) begin
      rem  <= n;
      res  <= '0;
      bitq <= ROOT_BIT_TOP;
    end else if (!done) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitq;
      end else begin
        res <= res >> 1;
      end
      bitq <= bitq >> 2;
    end
  end
endmodule

// ===== sv/gapf_dp.sv =====
// Datapath of the grid path finder: map memory, node store, path buffer,
// scan logic, score arithmetic and result register. Uses gapf_pkg and gapf_isqrt.
module gapf_dp #(
  parameter int NODE_SLOTS    = 128,
  parameter int PATH_CAPACITY = 15,
  parameter int GRID_SIDE_MAX = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  gapf_pkg::cmd_t  cmd,
  output gapf_pkg::stat_t st,
  input  gapf_pkg::in_t   item,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_data,
  output logic            result_valid,
  output gapf_pkg::out_t  result
);
  import gapf_pkg::*;

  localparam int CMAX  = (GRID_SIDE_MAX > 16) ? GRID_SIDE_MAX : 16;
  localparam int CW    = $clog2(CMAX + 1) + 1;
  localparam int CELLS = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(NODE_SLOTS);
  localparam int UW    = NW + 1;
  localparam int LW    = $clog2(PATH_CAPACITY + 1);
  localparam int CAW   = $clog2(PATH_CAPACITY);
  localparam int SQW   = 2 * CW + 3;
  localparam logic [CW-1:0] GSIDE = CW'(GRID_SIDE_MAX);

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [15:0]   g;
    logic [15:0]   f;
    logic [NW-1:0] parent;
  } node_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    logic [2*CW-1:0] a;
    a = (2*CW)'(y) * (2*CW)'(GRID_SIDE_MAX) + (2*CW)'(x);
    return a[AW-1:0];
  endfunction

  function automatic logic on_board(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                    input logic [CW-1:0] side);
    return !x[CW-1] && !y[CW-1] && (x < side) && (y < side);
  endfunction

  // Configuration and map.
  logic [4:0]    board_side;
  logic [CW-1:0] eff_side;
  logic [1:0]    map_mem [CELLS];
  logic [1:0]    map_q;
  logic [AW-1:0] clr, map_ra, cell_wa;
  logic          cell_in_range;

  // Request, search and trace state.
  logic signed [CW-1:0] sx, sy, gx, gy, cx, cy, nx, ny, cpx, cpy;
  logic [15:0]   cg, gj, low;
  logic [16:0]   t;
  logic [2:0]    d;
  logic [NW-1:0] best, j, c, scan_d, nd_wa, nd_ra;
  logic          best_v, jf, scan_v, nd_we;
  logic [UW-1:0] scan_i, nodes_used;
  logic [NODE_SLOTS-1:0] open_q;
  node_t         node_mem [NODE_SLOTS];
  node_t         node_q, nd_wd;
  logic [7:0]    chain_mem [PATH_CAPACITY];
  logic [7:0]    chain_q;
  logic [LW-1:0] len, k;
  logic [CAW-1:0] chain_ra;

  // Heuristic and weight terms.
  logic signed [CW:0] ddx, ddy;
  logic [CW:0]   adx, ady;
  logic [31:0]   hn;
  logic [15:0]   h, gnew, fnew, w_next;
  logic          sq_done, better, nb_goal;

  assign eff_side = (CW'(board_side) > GSIDE) ? GSIDE : CW'(board_side);
  assign cell_in_range = (CW'(item.cell_x) < GSIDE) && (CW'(item.cell_y) < GSIDE);
  assign cell_wa = cell_addr(CW'(item.cell_x), CW'(item.cell_y));
  assign map_ra  = cmd.goal_rd ? cell_addr(gx, gy) : cell_addr(nx, ny);

  always_ff @(posedge clk) begin
    if (rst) begin
      board_side <= SIDE_RESET;
      clr        <= '0;
    end else begin
      if (cfg_we) board_side <= cfg_data;
      if (cmd.clear_step) clr <= clr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      map_mem[clr] <= 2'b00;
    end else if (cmd.cell_wr && cell_in_range) begin
      map_mem[cell_wa] <= {item.cell_blocked, item.cell_occupied};
    end
    map_q <= map_mem[map_ra];
  end

  // Euclidean heuristic from the neighbor to the goal.
  assign ddx = (CW+1)'(nx) - (CW+1)'(gx);
  assign ddy = (CW+1)'(ny) - (CW+1)'(gy);
  assign adx = ddx[CW] ? $unsigned(-ddx) : $unsigned(ddx);
  assign ady = ddy[CW] ? $unsigned(-ddy) : $unsigned(ddy);
  assign hn  = 32'(SQW'(adx) * SQW'(adx) + SQW'(ady) * SQW'(ady)) << 16;

  gapf_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.nb_slot),
    .n    (hn),
    .done (sq_done),
    .root (h)
  );

  assign nb_goal = (nx == gx) && (ny == gy);

  always_comb begin
    if (!on_board(nx, ny, eff_side) || map_q[1]) begin
      w_next = SCORE_CAP;
    end else if (map_q[0] && !nb_goal) begin
      w_next = SCORE_CAP;
    end else begin
      w_next = (d >= DIR_FIRST_DIAG) ? W_DIAG : W_STRAIGHT;
    end
  end

  assign better = t < {1'b0, gj};
  assign gnew   = sat16(t);
  assign fnew   = sat16(17'(gnew) + 17'(h));

  // Node store ports.
  always_comb begin
    nd_we = 1'b0;
    nd_wa = j;
    nd_wd = '{px: nx, py: ny, g: gnew, f: fnew, parent: best};
    if (cmd.init) begin
      nd_we = 1'b1;
      nd_wa = '0;
      nd_wd = '{px: sx, py: sy, g: '0, f: '0, parent: '0};
    end else if (cmd.nb_slot && !jf) begin
      nd_we = 1'b1;
      nd_wa = nodes_used[NW-1:0];
      nd_wd = '{px: nx, py: ny, g: SCORE_CAP, f: SCORE_CAP, parent: '0};
    end else if (cmd.nb_upd && better) begin
      nd_we = 1'b1;
    end
  end

  always_comb begin
    priority if (cmd.min_pick) nd_ra = best;
    else if (cmd.nb_slot)      nd_ra = j;
    else if (cmd.tr_step)      nd_ra = c;
    else if (cmd.tr_par)       nd_ra = node_q.parent;
    else                       nd_ra = scan_i[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (nd_we) node_mem[nd_wa] <= nd_wd;
    node_q <= node_mem[nd_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_q <= '0;
    end else if (cmd.init) begin
      open_q <= NODE_SLOTS'(1);
    end else if (cmd.min_pick) begin
      open_q[best] <= 1'b0;
    end else if (cmd.nb_upd && better) begin
      open_q[j] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v <= 1'b0;
    end else if (cmd.min_init || cmd.nb_init) begin
      scan_v <= 1'b0;
    end else if (cmd.min_scan || cmd.nb_scan) begin
      scan_v <= (scan_i != nodes_used);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      sx <= CW'(item.start_x);
      sy <= CW'(item.start_y);
      gx <= CW'(item.goal_x);
      gy <= CW'(item.goal_y);
    end
    if (cmd.init) nodes_used <= UW'(1);
    if (cmd.min_init || cmd.nb_init) scan_i <= '0;
    if ((cmd.min_scan || cmd.nb_scan) && (scan_i != nodes_used)) begin
      scan_i <= scan_i + UW'(1);
      scan_d <= scan_i[NW-1:0];
    end
    if (cmd.min_init) begin
      low    <= SCORE_CAP;
      best_v <= 1'b0;
    end
    if (cmd.min_scan && scan_v && open_q[scan_d] && (node_q.f <= low)) begin
      low    <= node_q.f;
      best   <= scan_d;
      best_v <= 1'b1;
    end
    if (cmd.cur_load) begin
      cx <= node_q.px;
      cy <= node_q.py;
      cg <= node_q.g;
      d  <= '0;
    end
    if (cmd.nb_init) begin
      nx <= cx + CW'(dir_dx(d));
      ny <= cy + CW'(dir_dy(d));
      jf <= 1'b0;
    end
    if (cmd.nb_scan && scan_v && (node_q.px == nx) && (node_q.py == ny)) begin
      j  <= scan_d;
      jf <= 1'b1;
    end
    if (cmd.nb_slot) begin
      t <= 17'(cg) + 17'(w_next);
      if (!jf) begin
        j          <= nodes_used[NW-1:0];
        nodes_used <= nodes_used + UW'(1);
        gj         <= SCORE_CAP;
      end
    end
    if (cmd.nb_jread && jf) gj <= node_q.g;
    if (cmd.nb_upd) d <= d + 3'd1;
    if (cmd.tr_init) begin
      c   <= best;
      cpx <= cx;
      cpy <= cy;
      len <= '0;
      k   <= '0;
    end
    if (cmd.tr_step) len <= len + LW'(1);
    if (cmd.tr_par) c <= node_q.parent;
    if (cmd.tr_pl) begin
      cpx <= node_q.px;
      cpy <= node_q.py;
    end
    if (cmd.em_out) k <= k + LW'(1);
  end

  // Path buffer: filled goal first, read back start first.
  assign chain_ra = CAW'(len - LW'(1) - k);

  always_ff @(posedge clk) begin
    if (cmd.tr_step) chain_mem[len[CAW-1:0]] <= {cpx[3:0], cpy[3:0]};
    chain_q <= chain_mem[chain_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.em_out || cmd.fail;
    end
    if (cmd.fail) begin
      result <= '{found: 1'b0, step_x: '0, step_y: '0, step_index: '0, last: 1'b1};
    end else if (cmd.em_out) begin
      result <= '{found: 1'b1, step_x: chain_q[7:4], step_y: chain_q[3:0],
                  step_index: 4'(k), last: st.em_last};
    end
  end

  assign st.clear_last = (clr == AW'(CELLS - 1));
  assign st.goal_bad   = !on_board(gx, gy, eff_side) || map_q[1];
  assign st.scan_done  = (scan_i == nodes_used) && !scan_v;
  assign st.best_valid = best_v;
  assign st.at_goal    = (node_q.px == gx) && (node_q.py == gy);
  assign st.j_found    = jf;
  assign st.store_full = (nodes_used >= UW'(NODE_SLOTS));
  assign st.sqrt_done  = sq_done;
  assign st.dir_last   = (d == DIR_LAST);
  assign st.path_over  = (len == LW'(PATH_CAPACITY));
  assign st.trace_end  = (c == '0);
  assign st.em_last    = ((k + LW'(1)) == len);
endmodule

// ===== sv/gapf_ctrl.sv =====
// Sequencer of the grid path finder: one-hot state machine issuing
// datapath commands. Uses gapf_pkg for the command and status types.
module gapf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            operation,
  input  gapf_pkg::stat_t st,
  output gapf_pkg::cmd_t  cmd,
  output logic            busy
);
  import gapf_pkg::*;

  typedef enum logic [21:0] {
    S_CLEAR    = 22'h000001,
    S_IDLE     = 22'h000002,
    S_GOAL_RD  = 22'h000004,
    S_GOAL_CHK = 22'h000008,
    S_INIT     = 22'h000010,
    S_MIN_INIT = 22'h000020,
    S_MIN_SCAN = 22'h000040,
    S_MIN_PICK = 22'h000080,
    S_CUR_LOAD = 22'h000100,
    S_NB_INIT  = 22'h000200,
    S_NB_SCAN  = 22'h000400,
    S_NB_SLOT  = 22'h000800,
    S_NB_JREAD = 22'h001000,
    S_NB_SQRT  = 22'h002000,
    S_NB_UPD   = 22'h004000,
    S_TR_INIT  = 22'h008000,
    S_TR_STEP  = 22'h010000,
    S_TR_PAR   = 22'h020000,
    S_TR_PL    = 22'h040000,
    S_EM_RD    = 22'h080000,
    S_EM_OUT   = 22'h100000,
    S_FAIL     = 22'h200000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (operation == OP_PATH) begin
            cmd.load_req = 1'b1;
            state_next   = S_GOAL_RD;
          end else begin
            cmd.cell_wr = 1'b1;
          end
        end
      end
      S_GOAL_RD: begin
        cmd.goal_rd = 1'b1;
        state_next  = S_GOAL_CHK;
      end
      S_GOAL_CHK: state_next = st.goal_bad ? S_FAIL : S_INIT;
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_MIN_INIT;
      end
      S_MIN_INIT: begin
        cmd.min_init = 1'b1;
        state_next   = S_MIN_SCAN;
      end
      S_MIN_SCAN: begin
        cmd.min_scan = 1'b1;
        if (st.scan_done) state_next = S_MIN_PICK;
      end
      S_MIN_PICK: begin
        if (!st.best_valid) begin
          state_next = S_FAIL;
        end else begin
          cmd.min_pick = 1'b1;
          state_next   = S_CUR_LOAD;
        end
      end
      S_CUR_LOAD: begin
        cmd.cur_load = 1'b1;
        state_next   = st.at_goal ? S_TR_INIT : S_NB_INIT;
      end
      S_NB_INIT: begin
        cmd.nb_init = 1'b1;
        state_next  = S_NB_SCAN;
      end
      S_NB_SCAN: begin
        cmd.nb_scan = 1'b1;
        if (st.scan_done) state_next = S_NB_SLOT;
      end
      S_NB_SLOT: begin
        if (!st.j_found && st.store_full) begin
          state_next = S_FAIL;
        end else begin
          cmd.nb_slot = 1'b1;
          state_next  = S_NB_JREAD;
        end
      end
      S_NB_JREAD: begin
        cmd.nb_jread = 1'b1;
        state_next   = S_NB_SQRT;
      end
      S_NB_SQRT: begin
        if (st.sqrt_done) state_next = S_NB_UPD;
      end
      S_NB_UPD: begin
        cmd.nb_upd = 1'b1;
        state_next = st.dir_last ? S_MIN_INIT : S_NB_INIT;
      end
      S_TR_INIT: begin
        cmd.tr_init = 1'b1;
        state_next  = S_TR_STEP;
      end
      S_TR_STEP: begin
        if (st.path_over) begin
          state_next = S_FAIL;
        end else begin
          cmd.tr_step = 1'b1;
          state_next  = st.trace_end ? S_EM_RD : S_TR_PAR;
        end
      end
      S_TR_PAR: begin
        cmd.tr_par = 1'b1;
        state_next = S_TR_PL;
      end
      S_TR_PL: begin
        cmd.tr_pl  = 1'b1;
        state_next = S_TR_STEP;
      end
      S_EM_RD: state_next = S_EM_OUT;
      S_EM_OUT: begin
        cmd.em_out = 1'b1;
        state_next = st.em_last ? S_IDLE : S_EM_RD;
      end
      S_FAIL: begin
        cmd.fail   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== sv/grid_astar_path_finder.sv =====
// Top level of the grid path finder: A* search over an eight-neighbor cell map.
// Depends on gapf_pkg, gapf_ctrl, gapf_dp (which holds gapf_isqrt).
//
//   Channel   Signals                   Direction  Handshake
//   command   start, busy, item         in         taken when start is high and busy is low
//   result    result_valid, result      out        one-cycle strobe, cannot be held off
//   config    cfg_we, cfg_data          in         written on any edge with cfg_we high
//
// After reset the map is cleared one cell per cycle, until all GRID_SIDE_MAX squared cells are clear,
// with busy high. A cell-write item completes in its accept cycle. A search item
// first reads and checks the goal cell and initialises the node store, then per
// expansion scans the store for the minimum and loads the chosen node, plus, for each
// of the eight neighbors, looks it up in the store, takes a slot, reads its score,
// waits on the shared square-root unit and updates. The path is traced back cell by
// cell and then sent start first, one cell per item. The sequencer works on one item
// at a time; results leave through a register and are never stalled.
module grid_astar_path_finder #(
  parameter int NODE_SLOTS    = 128,
  parameter int PATH_CAPACITY = 15,
  parameter int GRID_SIDE_MAX = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gapf_pkg::in_t  item,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data,
  output logic           result_valid,
  output gapf_pkg::out_t result
);
  import gapf_pkg::*;

  // The controller and the datapath only talk through these two structs.
  cmd_t  cmd;
  stat_t st;

  gapf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(item.operation),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  gapf_dp #(
    .NODE_SLOTS   (NODE_SLOTS),
    .PATH_CAPACITY(PATH_CAPACITY),
    .GRID_SIDE_MAX(GRID_SIDE_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .result      (result)
  );

  // A result item only ever follows a cycle in which the sequencer was working.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result item without a search in progress");

  // A failure is always the only and final item of its request.
  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.last && result.step_x == 4'd0
                                         && result.step_y == 4'd0))
    else $error("failure item not final or not zeroed");

  // Once the final item of a request is out, the block is ready for a new item.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("block still busy after the final result item");
endmodule

// ===== tb/grid_astar_path_finder_tb.sv =====
// Self-checking testbench of the grid path finder: directed table, then random phases.
// Depends on gapf_pkg and grid_astar_path_finder; it carries its own A* search predictor.
`timescale 1ns / 100ps

module grid_astar_path_finder_tb;
  import gapf_pkg::*;

  localparam int SLOTS    = 128;
  localparam int PATH_MAX = 15;
  localparam int SIDE_MAX = 16;
  localparam int CAP      = 12800;
  localparam int WATCHDOG = 1000000;

  typedef struct {
    int   side_wr;  // -1 keeps the board size, otherwise it is written first
    in_t  it;
    bit   typed;    // want holds the one result expected
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  item = '0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic result_valid;
  out_t result;

  // Predictor copy of the block's state.
  bit blk_map[SIDE_MAX*SIDE_MAX];
  bit occ_map[SIDE_MAX*SIDE_MAX];
  int board = SIDE_RESET;
  int dist_tab[17][17];  // Euclidean distance in Q8.8 for offsets 0..16

  out_t path_q[$];  // results still to come, oldest first
  int   errors = 0;
  bit   idle_on = 1'b1;
  int   quiet = 0;
  row_t rows[$];

  grid_astar_path_finder DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit on_board(int x, int y);
    int s;
    s = (board > SIDE_MAX) ? SIDE_MAX : board;
    return x >= 0 && y >= 0 && x < s && y < s;
  endfunction

  function automatic out_t mk_out(bit fnd, int x, int y, int k, bit lst);
    out_t o;
    o.found = fnd; o.step_x = x[3:0]; o.step_y = y[3:0];
    o.step_index = k[3:0]; o.last = lst;
    return o;
  endfunction

  // A* over eight neighbors; pushes either the whole path or one failure result.
  function automatic void astar_predict(int sx, int sy, int gx, int gy);
    int px[SLOTS], py[SLOTS], g[SLOTS], f[SLOTS], par[SLOTS];
    bit open[SLOTS];
    int used, best, low, cx, cy, nx, ny, j, w, t, c, len;
    int chain[PATH_MAX];
    int ddx[8] = '{1, 0, 0, -1, -1, -1, 1, 1};
    int ddy[8] = '{0, 1, -1, 0, 1, -1, 1, -1};
    if (!on_board(gx, gy) || blk_map[gy*SIDE_MAX + gx]) begin
      path_q.push_back(mk_out(0, 0, 0, 0, 1));
      return;
    end
    foreach (open[i]) open[i] = 0;
    px[0] = sx; py[0] = sy; g[0] = 0; f[0] = 0; open[0] = 1; par[0] = 0;
    used = 1;
    forever begin
      best = -1;
      low = CAP;
      // Ties go to the highest index, hence the <= in the scan.
      for (int i = 0; i < used; i++)
        if (open[i] && f[i] <= low) begin
          low = f[i]; best = i;
        end
      if (best < 0) begin
        path_q.push_back(mk_out(0, 0, 0, 0, 1));
        return;
      end
      open[best] = 0;
      cx = px[best]; cy = py[best];
      if (cx == gx && cy == gy) begin
        len = 0; c = best;
        forever begin
          if (len == PATH_MAX) begin
            path_q.push_back(mk_out(0, 0, 0, 0, 1));
            return;
          end
          chain[len++] = c;
          if (c == 0) break;
          c = par[c];
        end
        for (int k = 0; k < len; k++)
          path_q.push_back(mk_out(1, px[chain[len-1-k]], py[chain[len-1-k]], k, k + 1 == len));
        return;
      end
      for (int d = 0; d < 8; d++) begin
        nx = cx + ddx[d]; ny = cy + ddy[d];
        j = -1;
        for (int i = 0; i < used; i++)
          if (px[i] == nx && py[i] == ny) j = i;
        if (j < 0) begin
          // Even cells off the board take a slot.
          if (used >= SLOTS) begin
            path_q.push_back(mk_out(0, 0, 0, 0, 1));
            return;
          end
          j = used++;
          px[j] = nx; py[j] = ny; g[j] = CAP; f[j] = CAP;
        end
        w = dist_tab[1][(d >= 4) ? 1 : 0];
        if (!on_board(nx, ny) || blk_map[ny*SIDE_MAX + nx]) w = CAP;
        else if (occ_map[ny*SIDE_MAX + nx] && !(nx == gx && ny == gy)) w = CAP;
        t = g[best] + w;
        if (t < g[j]) begin
          par[j] = best;
          g[j] = t;
          f[j] = t + dist_tab[(nx > gx) ? nx - gx : gx - nx][(ny > gy) ? ny - gy : gy - ny];
          open[j] = 1;
        end
      end
    end
  endfunction

  function automatic row_t cell_row(int side_wr, int x, int y, bit b, bit o);
    row_t r;
    r.side_wr = side_wr; r.typed = 0; r.want = '0;
    r.it = '0;
    r.it.operation = OP_CELL; r.it.cell_x = x[3:0]; r.it.cell_y = y[3:0];
    r.it.cell_blocked = b; r.it.cell_occupied = o;
    return r;
  endfunction

  function automatic row_t path_row(int side_wr, int sx, int sy, int gx, int gy,
                                    bit typed = 0, out_t want = '0);
    row_t r;
    r.side_wr = side_wr; r.typed = typed; r.want = want;
    r.it = '0;
    r.it.operation = OP_PATH; r.it.start_x = sx[3:0]; r.it.start_y = sy[3:0];
    r.it.goal_x = gx[3:0]; r.it.goal_y = gy[3:0];
    return r;
  endfunction

  // Board size writes happen only with nothing in flight.
  task automatic set_board(int v);
    start = 1'b0;
    wait (path_q.size() == 0);
    @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v[4:0];
    @(negedge clk);
    cfg_we = 1'b0;
    board = v & 31;
  endtask

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send(in_t it, bit typed, out_t want);
    if (idle_on && $urandom_range(99) < 30) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1'b1;
    item = it;
    do @(posedge clk); while (busy);
    if (it.operation == OP_CELL) begin
      blk_map[it.cell_y*SIDE_MAX + it.cell_x] = it.cell_blocked;
      occ_map[it.cell_y*SIDE_MAX + it.cell_x] = it.cell_occupied;
    end else if (typed) begin
      path_q.push_back(want);
    end else begin
      astar_predict(it.start_x, it.start_y, it.goal_x, it.goal_y);
    end
    @(negedge clk);
  endtask

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (!rst && result_valid) begin
      if (path_q.size() == 0) begin
        $error("unexpected result %p", result);
        errors++;
      end else begin
        e = path_q.pop_front();
        if (result.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, result.found); errors++;
        end
        if (result.step_x !== e.step_x) begin
          $error("step_x: expected %0d, got %0d", e.step_x, result.step_x); errors++;
        end
        if (result.step_y !== e.step_y) begin
          $error("step_y: expected %0d, got %0d", e.step_y, result.step_y); errors++;
        end
        if (result.step_index !== e.step_index) begin
          $error("step_index: expected %0d, got %0d", e.step_index, result.step_index);
          errors++;
        end
        if (result.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, result.last); errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("grid_astar_path_finder_tb failed");
      $finish;
    end
  end

  initial begin
    in_t it;
    int s, lim, r;
    int sides[8] = '{16, 10, 0, 31, 1, 5, 12, 4};
    // Distance table: round(256 * sqrt(dx^2 + dy^2)) by integer square root.
    for (int a = 0; a <= 16; a++)
      for (int b = 0; b <= 16; b++) begin
        int n;
        n = (a*a + b*b) << 16;
        r = 0;
        while ((r + 1)*(r + 1) <= n) r++;
        if (n - r*r > r) r++;
        dist_tab[a][b] = r;
      end
    foreach (blk_map[i]) begin
      blk_map[i] = 0; occ_map[i] = 0;
    end

    // Directed rows. The board starts at its reset size of 10.
    rows.push_back(path_row(-1, 3, 3, 3, 3, 1, mk_out(1, 3, 3, 0, 1)));   // start is goal
    rows.push_back(path_row(-1, 0, 0, 12, 2, 1, mk_out(0, 0, 0, 0, 1)));  // goal off board
    rows.push_back(cell_row(-1, 5, 5, 1, 0));
    rows.push_back(path_row(-1, 0, 0, 5, 5, 1, mk_out(0, 0, 0, 0, 1)));   // blocked goal
    rows.push_back(cell_row(-1, 15, 15, 1, 1));                           // stored, off board
    rows.push_back(cell_row(-1, 2, 0, 0, 1));
    rows.push_back(path_row(-1, 0, 0, 4, 0));                             // detour round a piece
    rows.push_back(path_row(-1, 0, 0, 2, 0));                             // occupied goal
    rows.push_back(path_row(-1, 15, 15, 9, 9));                           // start off board
    rows.push_back(path_row(-1, 0, 0, 9, 9));
    rows.push_back(cell_row(-1, 5, 5, 0, 0));
    rows.push_back(path_row(16, 0, 0, 15, 15, 1, mk_out(0, 0, 0, 0, 1))); // corner now blocked
    rows.push_back(path_row(-1, 15, 15, 15, 15, 1, mk_out(0, 0, 0, 0, 1)));
    rows.push_back(cell_row(-1, 15, 15, 0, 0));
    rows.push_back(path_row(-1, 15, 15, 15, 15, 1, mk_out(1, 15, 15, 0, 1)));
    rows.push_back(path_row(0, 0, 0, 0, 0, 1, mk_out(0, 0, 0, 0, 1)));   // empty board
    rows.push_back(path_row(1, 0, 0, 0, 0, 1, mk_out(1, 0, 0, 0, 1)));
    rows.push_back(path_row(-1, 0, 0, 1, 0, 1, mk_out(0, 0, 0, 0, 1)));
    rows.push_back(path_row(31, 0, 0, 14, 0));                            // exactly full path
    rows.push_back(cell_row(4, 1, 0, 1, 0));                              // walled-in start
    rows.push_back(cell_row(-1, 1, 1, 1, 0));
    rows.push_back(cell_row(-1, 0, 1, 1, 0));
    rows.push_back(path_row(-1, 0, 0, 3, 3));
    rows.push_back(cell_row(-1, 1, 0, 0, 0));
    rows.push_back(cell_row(-1, 1, 1, 0, 0));
    rows.push_back(cell_row(-1, 0, 1, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].side_wr >= 0) set_board(rows[i].side_wr);
      send(rows[i].it, rows[i].typed, rows[i].want);
    end

    // Random phases: map edits and searches mixed on each board, edits a little more often.
    foreach (sides[p]) begin
      set_board(sides[p]);
      idle_on = (p != 3);  // one phase runs with no gaps on the command side
      s = (sides[p] > SIDE_MAX) ? SIDE_MAX : sides[p];
      lim = (s == 0) ? 0 : s - 1;
      for (int n = 0; n < 10; n++) begin
        it = in_t'({$urandom, $urandom});
        it.operation = ($urandom_range(99) < 55) ? OP_CELL : OP_PATH;
        if ($urandom_range(9) != 0) begin
          it.cell_x = 4'($urandom_range(lim)); it.cell_y = 4'($urandom_range(lim));
          it.start_x = 4'($urandom_range(lim)); it.start_y = 4'($urandom_range(lim));
          it.goal_x = 4'($urandom_range(lim)); it.goal_y = 4'($urandom_range(lim));
        end
        it.cell_blocked = ($urandom_range(99) < 25);
        it.cell_occupied = ($urandom_range(99) < 15);
        send(it, 0, '0);
      end
    end
    start = 1'b0;

    wait (path_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("grid_astar_path_finder_tb passed");
    end else begin
      $display("grid_astar_path_finder_tb failed");
    end
    $finish;
  end

endmodule
